@@ sv/assert_macros.svh @@
// assertion helpers for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AERC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AERC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/aerc_pkg.sv @@
// ----------------------------------------------------------------------------
// aerc_pkg
// Types, constants and tables for the echo / reverb comb filter.
// ----------------------------------------------------------------------------
package aerc_pkg;

    localparam int RING_DEPTH  = 65536;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int LEN_W  = 16;
    localparam int CMP_W  = (PTR_W > LEN_W + 1) ? PTR_W : LEN_W + 1;
    localparam int CFG_DATA_W = 16;

    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] GAIN_Q15 = GAIN_W'(29491);
    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int SUM_W  = SAMPLE_BITS + 1;

    localparam int ECHO_FULL = 44000;
    localparam logic [LEN_W-1:0] ECHO_LEN [8] = '{
        LEN_W'(0), LEN_W'(0),
        LEN_W'(ECHO_FULL / 4), LEN_W'(ECHO_FULL / 2),
        LEN_W'(ECHO_FULL * 3 / 4), LEN_W'(ECHO_FULL),
        LEN_W'(0), LEN_W'(0)
    };

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [PTR_W-1:0]       t_hwm;
    typedef logic [CMP_W-1:0]       t_cmp;
    typedef logic [LEN_W-1:0]       t_len;

    typedef enum logic {
        MODE_ECHO   = 1'b0,
        MODE_REVERB = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_ECHO_CODE  = 2'd1,
        CFG_REVERB_LEN = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_addr addr;
        logic  hit;
    } t_rd_info;

    typedef struct packed {
        t_mode mode;
        logic  hit;
        logic  fwd;
    } t_mix_ctl;

endpackage

@@ sv/aerc_ram.sv @@
// ----------------------------------------------------------------------------
// aerc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aerc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/aerc_ptr.sv @@
// ----------------------------------------------------------------------------
// aerc_ptr
// Ring pointer with wrap at the selected length, and a fill mark that tells
// which ring words have been written since reset.
// ----------------------------------------------------------------------------
module aerc_ptr import aerc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_mode    i_mode,
    input  logic [2:0] i_code,
    input  t_len     i_rlen,
    output t_rd_info o_rd
);

    t_addr r_ptr, n_ptr;
    t_hwm  r_hwm, n_hwm;
    t_len  limit;
    t_cmp  ptr_inc;
    t_hwm  ptr_hwm_inc;

    always_comb begin
        limit       = (i_mode == MODE_REVERB) ? i_rlen : ECHO_LEN[i_code];
        ptr_inc     = t_cmp'(r_ptr) + t_cmp'(1);
        ptr_hwm_inc = t_hwm'(r_ptr) + t_hwm'(1);
        n_ptr = r_ptr;
        n_hwm = r_hwm;
        if (i_adv) begin
            if (ptr_inc > t_cmp'(limit) || ptr_inc >= t_cmp'(RING_DEPTH)) begin
                n_ptr = '0;
            end else begin
                n_ptr = ptr_inc[ADDR_W-1:0];
            end
            if (ptr_hwm_inc > r_hwm) begin
                n_hwm = ptr_hwm_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_hwm <= '0;
        end else begin
            r_ptr <= n_ptr;
            r_hwm <= n_hwm;
        end
    end

    // words at or above the fill mark were never written and read as zero
    assign o_rd.addr = r_ptr;
    assign o_rd.hit  = (t_hwm'(r_ptr) < r_hwm);

endmodule

@@ sv/aerc_mix.sv @@
// ----------------------------------------------------------------------------
// aerc_mix
// Comb arithmetic: picks the delayed word and forms the output sample and
// the word written back to the ring.
// ----------------------------------------------------------------------------
module aerc_mix import aerc_pkg::*; (
    input  t_sample  i_x,
    input  t_mix_ctl i_ctl,
    input  t_sample  i_rdata,
    input  t_sample  i_fwd_data,
    output t_sample  o_y,
    output t_sample  o_wdata
);

    t_sample              d;
    logic [PROD_W-1:0]    prod;
    t_sample              scaled;
    logic [SUM_W-1:0]     echo_sum;
    logic [SUM_W-1:0]     verb_sum;

    always_comb begin
        if (i_ctl.fwd) begin
            d = i_fwd_data;
        end else if (i_ctl.hit) begin
            d = i_rdata;
        end else begin
            d = '0;
        end
        prod     = PROD_W'(d) * PROD_W'(GAIN_Q15);
        scaled   = prod[PROD_W-1:GAIN_W];
        echo_sum = SUM_W'(i_x) + SUM_W'(scaled);
        verb_sum = SUM_W'(i_x) + SUM_W'(d[SAMPLE_BITS-1:1]);
        if (i_ctl.mode == MODE_REVERB) begin
            o_y     = verb_sum[SUM_W-1:1];
            o_wdata = verb_sum[SUM_W-1:1];
        end else begin
            o_y     = echo_sum[SUM_W-1:1];
            o_wdata = i_x;
        end
    end

endmodule

@@ sv/audio_echo_reverb_comb.sv @@
// ----------------------------------------------------------------------------
// audio_echo_reverb_comb
// Echo (feedforward) / reverb (feedback) comb filter on a circular delay
// line held in one synchronous RAM.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_sample_in
//   out       output     o_out_valid / i_out_ready o_sample_out
//   cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per cycle sustained unless the output stalls: the RAM is read on
// accept and written back as the word leaves the read stage, forwarding when
// a one-word ring reuses the entry; the read stage feeds the output register
// synchronous reset clears pointer, fill mark and config; no clearing pass
// an output stall holds the read stage, which then holds the input side
// ----------------------------------------------------------------------------
module audio_echo_reverb_comb import aerc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mode      r_mode;
    logic [2:0] r_code;
    t_len       r_rlen;

    logic     r_s1_valid, n_s1_valid;
    t_sample  r_s1_x;
    t_addr    r_s1_pos;
    t_mix_ctl r_s1_ctl;
    t_sample  r_fwd_data;
    logic     r_out_valid, n_out_valid;
    t_sample  r_out_sample;

    logic     accept;
    logic     s1_adv;
    t_rd_info rd;
    t_sample  rdata;
    t_sample  y;
    t_sample  wdata;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    aerc_ptr u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_mode  (r_mode),
        .i_code  (r_code),
        .i_rlen  (r_rlen),
        .o_rd    (rd)
    );

    aerc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (rd.addr),
        .o_rdata (rdata)
    );

    aerc_mix u_mix (
        .i_x        (r_s1_x),
        .i_ctl      (r_s1_ctl),
        .i_rdata    (rdata),
        .i_fwd_data (r_fwd_data),
        .o_y        (y),
        .o_wdata    (wdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_ECHO;
            r_code      <= '0;
            r_rlen      <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MODE:       r_mode <= t_mode'(i_cfg_data[0]);
                    CFG_ECHO_CODE:  r_code <= i_cfg_data[2:0];
                    CFG_REVERB_LEN: r_rlen <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x        <= i_sample_in;
            r_s1_pos      <= rd.addr;
            r_s1_ctl.mode <= r_mode;
            r_s1_ctl.hit  <= rd.hit;
            // entry still being written by the word ahead
            r_s1_ctl.fwd  <= r_s1_valid && (r_s1_pos == rd.addr);
        end
        if (s1_adv) begin
            r_fwd_data   <= wdata;
            r_out_sample <= y;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;

endmodule

@@ sv/aerc_checker.sv @@
// ----------------------------------------------------------------------------
// aerc_checker
// Port-level checks on the comb filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aerc_checker import aerc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);

    // a held word keeps its value
    `AERC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample_out))

    // a word leaves only when taken
    `AERC_ASSERT_NOW(a_out_drop, i_clk, i_rst_n, $fell(o_out_valid), $past(i_out_ready))

    // with nothing waiting at the output the input side is open
    `AERC_ASSERT_NOW(a_in_open, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // a new output word comes from a sample accepted and passed straight through the read stage
    `AERC_ASSERT_NOW(a_out_src, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2))

endmodule

bind audio_echo_reverb_comb aerc_checker u_aerc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);

@@ sim/audio_echo_reverb_comb_checker.sv @@
// ----------------------------------------------------------------------------
// audio_echo_reverb_comb_checker
// Watches the sample, result and register channels of the comb filter. Every
// accepted input word is run through a local comb model that keeps its own
// delay ring, pointer and registers. The predicted samples are queued, and
// each accepted output word is compared with the oldest one.
// ----------------------------------------------------------------------------
module audio_echo_reverb_comb_checker import aerc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_out,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_pending,
    output int                     o_errors
);

    localparam int unsigned DEPTH = 65536;
    localparam int unsigned GAIN  = 29491;
    localparam int unsigned ECHO_SPAN [8] = '{0, 0, 11000, 22000, 33000, 44000, 0, 0};

    t_sample     delay_ring [DEPTH];
    int unsigned ring_ptr;
    t_mode       comb_mode;
    logic [2:0]  echo_code;
    logic [15:0] reverb_len;
    t_sample     due_samples [$];

    function automatic t_sample comb_step(input t_sample x);
        t_sample     d;
        logic [16:0] mix;
        int unsigned span;
        d = delay_ring[ring_ptr];
        if (comb_mode == MODE_ECHO) begin
            mix = 17'(x) + 17'((32'(d) * GAIN) >> 15);
            delay_ring[ring_ptr] = x;
            span = ECHO_SPAN[echo_code];
        end else begin
            mix = 17'(x) + 17'(d >> 1);
            delay_ring[ring_ptr] = t_sample'(mix >> 1);
            span = reverb_len;
        end
        ring_ptr = ring_ptr + 1;
        if (ring_ptr > span || ring_ptr >= DEPTH) begin
            ring_ptr = 0;
        end
        return t_sample'(mix >> 1);
    endfunction

    always @(posedge i_clk) begin : watch
        t_sample want;
        if (!i_rst_n) begin
            foreach (delay_ring[k]) begin
                delay_ring[k] = '0;
            end
            ring_ptr   = 0;
            comb_mode  = MODE_ECHO;
            echo_code  = '0;
            reverb_len = '0;
            due_samples.delete();
            o_errors   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        comb_mode = t_mode'(i_cfg_data[0]);
                    end
                    CFG_ECHO_CODE: begin
                        echo_code = i_cfg_data[2:0];
                    end
                    CFG_REVERB_LEN: begin
                        reverb_len = i_cfg_data[15:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                due_samples.push_back(comb_step(i_sample_in));
            end
            if (i_out_valid && i_out_ready) begin
                if (due_samples.size() == 0) begin
                    $display("%0t: sample_out expected none, got %h", $time, i_sample_out);
                    o_errors++;
                end else begin
                    want = due_samples.pop_front();
                    if (i_sample_out !== want) begin
                        $display("%0t: sample_out expected %h, got %h",
                                 $time, want, i_sample_out);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = due_samples.size();
    end

endmodule

@@ sim/audio_echo_reverb_comb_test.sv @@
// ----------------------------------------------------------------------------
// audio_echo_reverb_comb_test
// Drives the comb filter with directed extremes, random sample runs under
// changing register settings and idling patterns, a long output hold-off,
// and a pause mid-run until every word is back. The checker beside the
// block predicts and compares.
// ----------------------------------------------------------------------------
module audio_echo_reverb_comb_test import aerc_pkg::*;;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          LONG_HOLD   = 300;
    localparam int          SEG_WORDS   = 195;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam t_sample     EDGE_SAMPLES [8] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                                                 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_sample_in;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] o_sample_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int          pending;
    int          errors;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_asks      = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int unsigned cycle_count    = 0;

    audio_echo_reverb_comb dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    audio_echo_reverb_comb_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return t_sample'(1) << $urandom_range(SAMPLE_BITS - 1);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default: begin
                send_idle_pct  = 24;
                recv_stall_pct = 24;
            end
        endcase
    endtask

    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // unused upper bits of mode and delay code carry junk
    task automatic set_comb(input t_mode m, input logic [2:0] code, input t_len len);
        write_reg(CFG_MODE, {15'($urandom), m});
        write_reg(CFG_ECHO_CODE, {13'($urandom), code});
        write_reg(CFG_REVERB_LEN, len);
    endtask

    initial begin
        t_mode      seg_mode;
        logic [2:0] seg_code;
        t_len       seg_len;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: echo with an unused code, one-word ring
        foreach (EDGE_SAMPLES[k]) begin
            send_sample(EDGE_SAMPLES[k]);
        end
        i_in_valid <= 1'b0;
        drain();

        // short reverb ring fed with full-scale samples
        set_comb(MODE_REVERB, 3'd7, 16'd2);
        repeat (6) send_sample('1);
        i_in_valid <= 1'b0;
        drain();
        write_reg(CFG_SPARE, '1);

        // longest echo, then the length drops under the pointer
        set_comb(MODE_ECHO, 3'd5, 16'd2);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        send_sample(16'h8000);
        send_sample('1);
        i_in_valid <= 1'b0;
        drain();
        write_reg(CFG_ECHO_CODE, {13'($urandom), 3'd6});
        send_sample('1);
        send_sample('1);
        send_sample('0);
        i_in_valid <= 1'b0;

        for (int seg = 0; seg < 10; seg++) begin
            drain();
            set_idling(seg);
            seg_mode = t_mode'($urandom_range(1));
            seg_code = 3'($urandom);
            seg_len  = ($urandom_range(3) == 0) ? t_len'($urandom) : t_len'($urandom_range(40));
            case (seg)
                0: begin
                    seg_mode = MODE_REVERB;
                    seg_len  = '0;
                end
                1: begin
                    seg_mode = MODE_ECHO;
                    seg_code = 3'd7;
                end
                2: begin
                    seg_mode = MODE_REVERB;
                    seg_len  = '1;
                end
                3: begin
                    seg_mode = MODE_ECHO;
                    seg_code = 3'd0;
                end
                default: begin
                end
            endcase
            set_comb(seg_mode, seg_code, seg_len);
            if (seg == 4) begin
                hold_asks++;
            end
            for (int k = 0; k < SEG_WORDS; k++) begin
                if (seg == 7 && k == SEG_WORDS / 2) begin
                    i_in_valid <= 1'b0;
                    drain();
                end
                send_sample(pick_sample());
            end
            i_in_valid <= 1'b0;
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
